>>> hw/rtl/rlp_pkg.sv
package rlp_pkg;

    // Sizes of the counter window
    localparam int KIND_COUNT = 8;
    localparam int SLOW_SLOTS = 5;
    localparam int OPEN_KIND  = 1;
    localparam int BUCKETS    = 9;
    localparam int TOTALS     = 8;

    // Field widths
    localparam int CNT_W    = 48;
    localparam int TICK_W   = 48;
    localparam int BYTE_W   = 32;
    localparam int FREQ_W   = 32;
    localparam int SLOW_W   = 16;
    localparam int OP_W     = 2;
    localparam int RKIND_W  = 4;
    localparam int ADDR_W   = 7;
    localparam int BKT_W    = 4;
    localparam int CFG_IDX_W = 1;

    // Milliseconds to ticks: compares are done in ticks*1000 units
    localparam int MS_TO_TICK = 1000;
    localparam int MS_W       = 10;
    localparam int TK_W       = TICK_W + MS_W;
    localparam int TKP_W      = TK_W + 1;
    localparam int LIM_W      = FREQ_W + MS_W;
    localparam int FS_W       = FREQ_W + SLOW_W;

    // Index widths
    localparam int KIND_W  = (KIND_COUNT > 1) ? $clog2(KIND_COUNT) : 1;
    localparam int SLOT_IW = (SLOW_SLOTS > 1) ? $clog2(SLOW_SLOTS) : 1;
    localparam int SCNT_W  = $clog2(SLOW_SLOTS + 1);
    localparam int TOT_IW  = $clog2(TOTALS);
    localparam int HIST_IW = $clog2(BUCKETS);
    localparam int KF_BITS = 3;

    // Opcodes
    localparam logic [OP_W-1:0] OP_RECORD = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW = 1'd1;
    localparam logic [FREQ_W-1:0]    FREQ_RST = 32'd10000000;
    localparam logic [SLOW_W-1:0]    SLOW_RST = 16'd25;

    // Window total indexes
    localparam int TOT_REQS  = 0;
    localparam int TOT_TICKS = 1;
    localparam int TOT_MAX   = 2;
    localparam int TOT_POST  = 3;
    localparam int TOT_BAD   = 4;
    localparam int TOT_SLOW  = 5;
    localparam int TOT_OK    = 6;
    localparam int TOT_MISS  = 7;

    // Per-kind field codes
    localparam logic [KF_BITS-1:0] KF_CALLS = 3'd0;
    localparam logic [KF_BITS-1:0] KF_BAD   = 3'd1;
    localparam logic [KF_BITS-1:0] KF_BYTES = 3'd2;
    localparam logic [KF_BITS-1:0] KF_TICKS = 3'd3;
    localparam logic [KF_BITS-1:0] KF_MAX   = 3'd4;

    // Read map
    localparam logic [ADDR_W-1:0] ADDR_HIST       = 7'd8;
    localparam logic [ADDR_W-1:0] ADDR_SLOW_TICKS = ADDR_HIST + ADDR_W'(BUCKETS);
    localparam logic [ADDR_W-1:0] ADDR_SLOW_BYTES = ADDR_SLOW_TICKS + ADDR_W'(SLOW_SLOTS);
    localparam logic [ADDR_W-1:0] ADDR_SLOW_CNT   = ADDR_SLOW_BYTES + ADDR_W'(SLOW_SLOTS);
    localparam logic [ADDR_W-1:0] ADDR_KIND       = 7'd32;

    // Histogram bucket upper limits in milliseconds
    localparam logic [MS_W-1:0] BUCKET_MS [BUCKETS-1] = '{
        10'd1, 10'd5, 10'd10, 10'd25, 10'd50, 10'd100, 10'd250, 10'd1000
    };

    typedef struct packed {
        logic [OP_W-1:0]    opcode;
        logic [RKIND_W-1:0] request_kind;
        logic               is_bad;
        logic [BYTE_W-1:0]  payload_bytes;
        logic [BYTE_W-1:0]  open_bytes;
        logic [TICK_W-1:0]  service_ticks;
        logic [TICK_W-1:0]  post_ticks;
        logic               open_succeeded;
        logic               open_missed;
        logic [ADDR_W-1:0]  read_address;
    } t_req;

    typedef struct packed {
        logic [CNT_W-1:0] read_data;
        logic [BKT_W-1:0] latency_bucket;
        logic             was_slow;
    } t_rsp;

    typedef struct packed {
        logic [CNT_W-1:0] calls;
        logic [CNT_W-1:0] bad;
        logic [CNT_W-1:0] bytes;
        logic [CNT_W-1:0] ticks;
        logic [CNT_W-1:0] max_ticks;
    } t_kind_cnt;

endpackage

>>> hw/rtl/rlp_in_if.sv
interface rlp_in_if;
    logic                          valid;
    logic                          ready;
    logic [rlp_pkg::OP_W-1:0]      opcode;
    logic [rlp_pkg::RKIND_W-1:0]   request_kind;
    logic                          is_bad;
    logic [rlp_pkg::BYTE_W-1:0]    payload_bytes;
    logic [rlp_pkg::BYTE_W-1:0]    open_bytes;
    logic [rlp_pkg::TICK_W-1:0]    service_ticks;
    logic [rlp_pkg::TICK_W-1:0]    post_ticks;
    logic                          open_succeeded;
    logic                          open_missed;
    logic [rlp_pkg::ADDR_W-1:0]    read_address;

    modport source (
        output valid, opcode, request_kind, is_bad, payload_bytes, open_bytes,
               service_ticks, post_ticks, open_succeeded, open_missed, read_address,
        input  ready
    );

    modport sink (
        input  valid, opcode, request_kind, is_bad, payload_bytes, open_bytes,
               service_ticks, post_ticks, open_succeeded, open_missed, read_address,
        output ready
    );
endinterface

>>> hw/rtl/rlp_out_if.sv
interface rlp_out_if;
    logic                        valid;
    logic                        ready;
    logic [rlp_pkg::CNT_W-1:0]   read_data;
    logic [rlp_pkg::BKT_W-1:0]   latency_bucket;
    logic                        was_slow;

    modport source (
        output valid, read_data, latency_bucket, was_slow,
        input  ready
    );

    modport sink (
        input  valid, read_data, latency_bucket, was_slow,
        output ready
    );
endinterface

>>> hw/rtl/request_latency_profiler.sv
// Request latency profiler: a window of performance counters.
// i_req carries one word per request record, counter read or window clear
// (valid/ready). o_rsp returns exactly one word per input word: the read
// counter, the histogram bucket and slow flag of a recorded request, or zero.
// Configuration (tick frequency, slow limit) is written through i_cfg_we,
// i_cfg_idx and i_cfg_data while no word is in flight.
// o_rsp.valid rises once the accepted word has passed the input register
// and then the result register.
// Throughput: one word per cycle while o_rsp is not stalled; all counter
// updates, the eight bucket compares and the five-slot sorted insert are
// done combinationally between the input and result registers.
// Threshold products (frequency times limits) are registered from the
// configuration registers.
// Reset clears all counters and the slow list and restores the default
// configuration. When o_rsp stalls, the result register holds its word,
// the input register fills, and i_req.ready drops after that.
module request_latency_profiler (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    rlp_in_if.sink                           i_req,
    rlp_out_if.source                        o_rsp,
    input  logic                             i_cfg_we,
    input  logic [rlp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rlp_pkg::FREQ_W-1:0]       i_cfg_data
);

    localparam int KF_OFS = rlp_pkg::KF_BITS;

    // Configuration and derived threshold products
    logic [rlp_pkg::FREQ_W-1:0] r_freq;
    logic [rlp_pkg::SLOW_W-1:0] r_slow;
    logic [rlp_pkg::FS_W-1:0]   r_fs;
    logic [rlp_pkg::LIM_W-1:0]  r_lim [rlp_pkg::BUCKETS-1];

    // Pipeline
    logic                       r_s0_vld;
    rlp_pkg::t_req              r_s0;
    logic [rlp_pkg::TK_W-1:0]   r_s0_tk;
    logic                       r_out_vld;
    rlp_pkg::t_rsp              r_rsp;
    rlp_pkg::t_rsp              n_rsp;
    logic                       w_adv;
    logic                       w_take;

    // Counter state
    logic [rlp_pkg::CNT_W-1:0]  r_tot  [rlp_pkg::TOTALS];
    logic [rlp_pkg::CNT_W-1:0]  n_tot  [rlp_pkg::TOTALS];
    rlp_pkg::t_kind_cnt         r_kind [rlp_pkg::KIND_COUNT];
    rlp_pkg::t_kind_cnt         n_kind [rlp_pkg::KIND_COUNT];
    logic [rlp_pkg::CNT_W-1:0]  r_hist [rlp_pkg::BUCKETS];
    logic [rlp_pkg::CNT_W-1:0]  n_hist [rlp_pkg::BUCKETS];
    logic [rlp_pkg::TICK_W-1:0] r_st   [rlp_pkg::SLOW_SLOTS];
    logic [rlp_pkg::TICK_W-1:0] n_st   [rlp_pkg::SLOW_SLOTS];
    logic [rlp_pkg::BYTE_W-1:0] r_sb   [rlp_pkg::SLOW_SLOTS];
    logic [rlp_pkg::BYTE_W-1:0] n_sb   [rlp_pkg::SLOW_SLOTS];
    logic [rlp_pkg::SCNT_W-1:0] r_scnt;
    logic [rlp_pkg::SCNT_W-1:0] n_scnt;

    // Decode of the word in the input register
    logic [rlp_pkg::KIND_W-1:0]  w_map_kind;
    logic [rlp_pkg::KIND_W-1:0]  w_sel_kind;
    logic                        w_is_open;
    logic                        w_slow;
    logic [rlp_pkg::BUCKETS-2:0] w_le;
    logic [rlp_pkg::BKT_W-1:0]   w_bucket;
    logic [rlp_pkg::SLOW_SLOTS-1:0] w_ge;
    logic                        w_ins;
    rlp_pkg::t_kind_cnt          w_kc;
    rlp_pkg::t_kind_cnt          w_kc_new;
    logic [rlp_pkg::ADDR_W-1:0]  w_koff;
    logic [rlp_pkg::ADDR_W-KF_OFS-1:0] w_rkind;
    logic [rlp_pkg::KF_BITS-1:0] w_rfield;
    logic [rlp_pkg::ADDR_W-1:0]  w_hidx;
    logic [rlp_pkg::ADDR_W-1:0]  w_tidx;
    logic [rlp_pkg::ADDR_W-1:0]  w_bidx;
    logic [rlp_pkg::CNT_W-1:0]   w_rdata;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq <= rlp_pkg::FREQ_RST;
            r_slow <= rlp_pkg::SLOW_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rlp_pkg::CFG_FREQ: r_freq <= i_cfg_data;
                rlp_pkg::CFG_SLOW: r_slow <= i_cfg_data[rlp_pkg::SLOW_W-1:0];
            endcase
        end
    end

    // Threshold products, registered from the configuration registers
    always_ff @(posedge i_clk) begin
        r_fs <= rlp_pkg::FS_W'(r_freq) * rlp_pkg::FS_W'(r_slow);
        for (int i = 0; i < rlp_pkg::BUCKETS - 1; i++) begin
            r_lim[i] <= rlp_pkg::LIM_W'(rlp_pkg::BUCKET_MS[i]) * rlp_pkg::LIM_W'(r_freq);
        end
    end

    // Handshake
    assign w_adv        = r_s0_vld && (!r_out_vld || o_rsp.ready);
    assign i_req.ready  = i_rst_n && (!r_s0_vld || w_adv);
    assign w_take       = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (w_take) begin
            r_s0_vld <= 1'b1;
        end else if (w_adv) begin
            r_s0_vld <= 1'b0;
        end
    end

    // Input register; ticks are scaled to millisecond compare units here
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_s0.opcode         <= i_req.opcode;
            r_s0.request_kind   <= i_req.request_kind;
            r_s0.is_bad         <= i_req.is_bad;
            r_s0.payload_bytes  <= i_req.payload_bytes;
            r_s0.open_bytes     <= i_req.open_bytes;
            r_s0.service_ticks  <= i_req.service_ticks;
            r_s0.post_ticks     <= i_req.post_ticks;
            r_s0.open_succeeded <= i_req.open_succeeded;
            r_s0.open_missed    <= i_req.open_missed;
            r_s0.read_address   <= i_req.read_address;
            r_s0_tk <= rlp_pkg::TK_W'(i_req.service_ticks) * rlp_pkg::TK_W'(rlp_pkg::MS_TO_TICK);
        end
    end

    // Kind mapping, slow flag and bucket compares
    always_comb begin
        if (int'(r_s0.request_kind) < rlp_pkg::KIND_COUNT) begin
            w_map_kind = rlp_pkg::KIND_W'(r_s0.request_kind);
        end else begin
            w_map_kind = '0;
        end
        w_is_open = (r_s0.request_kind == rlp_pkg::RKIND_W'(rlp_pkg::OPEN_KIND));
        // ticks >= floor(F*S/1000)  <=>  ticks*1000 + 999 >= F*S
        w_slow = (rlp_pkg::TKP_W'(r_s0_tk) + rlp_pkg::TKP_W'(rlp_pkg::MS_TO_TICK - 1))
                 >= rlp_pkg::TKP_W'(r_fs);
        for (int i = 0; i < rlp_pkg::BUCKETS - 1; i++) begin
            w_le[i] = (r_s0_tk <= rlp_pkg::TK_W'(r_lim[i]));
        end
        w_bucket = rlp_pkg::BKT_W'(rlp_pkg::BUCKETS - 1);
        for (int i = rlp_pkg::BUCKETS - 2; i >= 0; i--) begin
            if (w_le[i]) begin
                w_bucket = rlp_pkg::BKT_W'(i);
            end
        end
    end

    // Read address decode; the kind row has one shared read port
    always_comb begin
        w_koff   = r_s0.read_address - rlp_pkg::ADDR_KIND;
        w_rkind  = w_koff[rlp_pkg::ADDR_W-1:KF_OFS];
        w_rfield = w_koff[KF_OFS-1:0];
        w_hidx   = r_s0.read_address - rlp_pkg::ADDR_HIST;
        w_tidx   = r_s0.read_address - rlp_pkg::ADDR_SLOW_TICKS;
        w_bidx   = r_s0.read_address - rlp_pkg::ADDR_SLOW_BYTES;
        if (r_s0.opcode == rlp_pkg::OP_READ) begin
            w_sel_kind = w_rkind[rlp_pkg::KIND_W-1:0];
        end else begin
            w_sel_kind = w_map_kind;
        end
        w_kc = r_kind[w_sel_kind];
    end

    // Counter read mux
    always_comb begin
        w_rdata = '0;
        priority if (r_s0.read_address < rlp_pkg::ADDR_HIST) begin
            w_rdata = r_tot[r_s0.read_address[rlp_pkg::TOT_IW-1:0]];
        end else if (r_s0.read_address < rlp_pkg::ADDR_SLOW_TICKS) begin
            w_rdata = r_hist[w_hidx[rlp_pkg::HIST_IW-1:0]];
        end else if (r_s0.read_address < rlp_pkg::ADDR_SLOW_BYTES) begin
            if (w_tidx < rlp_pkg::ADDR_W'(r_scnt)) begin
                w_rdata = r_st[w_tidx[rlp_pkg::SLOT_IW-1:0]];
            end
        end else if (r_s0.read_address < rlp_pkg::ADDR_SLOW_CNT) begin
            if (w_bidx < rlp_pkg::ADDR_W'(r_scnt)) begin
                w_rdata = rlp_pkg::CNT_W'(r_sb[w_bidx[rlp_pkg::SLOT_IW-1:0]]);
            end
        end else if (r_s0.read_address == rlp_pkg::ADDR_SLOW_CNT) begin
            w_rdata = rlp_pkg::CNT_W'(r_scnt);
        end else if (r_s0.read_address >= rlp_pkg::ADDR_KIND) begin
            if (int'(w_rkind) < rlp_pkg::KIND_COUNT) begin
                unique case (w_rfield)
                    rlp_pkg::KF_CALLS: w_rdata = w_kc.calls;
                    rlp_pkg::KF_BAD:   w_rdata = w_kc.bad;
                    rlp_pkg::KF_BYTES: w_rdata = w_kc.bytes;
                    rlp_pkg::KF_TICKS: w_rdata = w_kc.ticks;
                    rlp_pkg::KF_MAX:   w_rdata = w_kc.max_ticks;
                    default:           w_rdata = '0;
                endcase
            end
        end else begin
            w_rdata = '0;
        end
    end

    // Updated kind row
    always_comb begin
        w_kc_new.calls = w_kc.calls + rlp_pkg::CNT_W'(1);
        w_kc_new.bad   = w_kc.bad + rlp_pkg::CNT_W'(r_s0.is_bad);
        w_kc_new.bytes = w_kc.bytes + rlp_pkg::CNT_W'(r_s0.payload_bytes);
        w_kc_new.ticks = w_kc.ticks + r_s0.service_ticks;
        if (r_s0.service_ticks > w_kc.max_ticks) begin
            w_kc_new.max_ticks = r_s0.service_ticks;
        end else begin
            w_kc_new.max_ticks = w_kc.max_ticks;
        end
    end

    // Slow list: slots at or above the new ticks stay, the new word goes
    // right after them, the rest shift down one slot
    always_comb begin
        for (int j = 0; j < rlp_pkg::SLOW_SLOTS; j++) begin
            w_ge[j] = (j < int'(r_scnt)) && (r_st[j] >= r_s0.service_ticks);
        end
        w_ins = w_is_open && w_slow && !w_ge[rlp_pkg::SLOW_SLOTS-1];
    end

    // Next state of the window
    always_comb begin
        n_tot  = r_tot;
        n_kind = r_kind;
        n_hist = r_hist;
        n_st   = r_st;
        n_sb   = r_sb;
        n_scnt = r_scnt;
        if (r_s0.opcode == rlp_pkg::OP_CLEAR) begin
            for (int i = 0; i < rlp_pkg::TOTALS; i++) n_tot[i] = '0;
            for (int i = 0; i < rlp_pkg::KIND_COUNT; i++) n_kind[i] = '0;
            for (int i = 0; i < rlp_pkg::BUCKETS; i++) n_hist[i] = '0;
            for (int i = 0; i < rlp_pkg::SLOW_SLOTS; i++) begin
                n_st[i] = '0;
                n_sb[i] = '0;
            end
            n_scnt = '0;
        end else if (r_s0.opcode == rlp_pkg::OP_RECORD) begin
            n_tot[rlp_pkg::TOT_REQS]  = r_tot[rlp_pkg::TOT_REQS] + rlp_pkg::CNT_W'(1);
            n_tot[rlp_pkg::TOT_TICKS] = r_tot[rlp_pkg::TOT_TICKS] + r_s0.service_ticks;
            if (r_s0.service_ticks > r_tot[rlp_pkg::TOT_MAX]) begin
                n_tot[rlp_pkg::TOT_MAX] = r_s0.service_ticks;
            end
            n_tot[rlp_pkg::TOT_POST] = r_tot[rlp_pkg::TOT_POST] + r_s0.post_ticks;
            n_tot[rlp_pkg::TOT_BAD]  = r_tot[rlp_pkg::TOT_BAD] + rlp_pkg::CNT_W'(r_s0.is_bad);
            n_tot[rlp_pkg::TOT_SLOW] = r_tot[rlp_pkg::TOT_SLOW] + rlp_pkg::CNT_W'(w_slow);
            if (w_is_open) begin
                n_tot[rlp_pkg::TOT_OK] =
                    r_tot[rlp_pkg::TOT_OK] + rlp_pkg::CNT_W'(r_s0.open_succeeded);
                n_tot[rlp_pkg::TOT_MISS] =
                    r_tot[rlp_pkg::TOT_MISS] + rlp_pkg::CNT_W'(r_s0.open_missed);
            end
            n_kind[w_map_kind] = w_kc_new;
            n_hist[w_bucket[rlp_pkg::HIST_IW-1:0]] =
                r_hist[w_bucket[rlp_pkg::HIST_IW-1:0]] + rlp_pkg::CNT_W'(1);
            if (w_ins) begin
                if (!w_ge[0]) begin
                    n_st[0] = r_s0.service_ticks;
                    n_sb[0] = r_s0.open_bytes;
                end
                for (int j = 1; j < rlp_pkg::SLOW_SLOTS; j++) begin
                    if (!w_ge[j]) begin
                        if (w_ge[j-1]) begin
                            n_st[j] = r_s0.service_ticks;
                            n_sb[j] = r_s0.open_bytes;
                        end else begin
                            n_st[j] = r_st[j-1];
                            n_sb[j] = r_sb[j-1];
                        end
                    end
                end
                if (int'(r_scnt) < rlp_pkg::SLOW_SLOTS) begin
                    n_scnt = r_scnt + rlp_pkg::SCNT_W'(1);
                end
            end
        end
    end

    // Window state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < rlp_pkg::TOTALS; i++) r_tot[i] <= '0;
            for (int i = 0; i < rlp_pkg::KIND_COUNT; i++) r_kind[i] <= '0;
            for (int i = 0; i < rlp_pkg::BUCKETS; i++) r_hist[i] <= '0;
            for (int i = 0; i < rlp_pkg::SLOW_SLOTS; i++) begin
                r_st[i] <= '0;
                r_sb[i] <= '0;
            end
            r_scnt <= '0;
        end else if (w_adv) begin
            r_tot  <= n_tot;
            r_kind <= n_kind;
            r_hist <= n_hist;
            r_st   <= n_st;
            r_sb   <= n_sb;
            r_scnt <= n_scnt;
        end
    end

    // Result word
    always_comb begin
        n_rsp = '0;
        if (r_s0.opcode == rlp_pkg::OP_READ) begin
            n_rsp.read_data = w_rdata;
        end else if (r_s0.opcode == rlp_pkg::OP_RECORD) begin
            n_rsp.latency_bucket = w_bucket;
            n_rsp.was_slow       = w_slow;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid          = r_out_vld;
    assign o_rsp.read_data      = r_rsp.read_data;
    assign o_rsp.latency_bucket = r_rsp.latency_bucket;
    assign o_rsp.was_slow       = r_rsp.was_slow;

endmodule
